>>> rtl/ctcg_pkg.sv
// shared types and constants of the ctc greedy decoder
`default_nettype none
package ctcg_pkg;

  localparam int SCORE_W  = 16;
  localparam int CFG_W    = 14;
  localparam int LABEL_W  = 13;
  localparam int KEPT_W   = 11;
  localparam int SUM_W    = 27;
  localparam int MEAN_W   = 16;
  localparam int QDEPTH   = 2;
  localparam int MAX_CLASSES_DEF = 8192;

  localparam logic [CFG_W-1:0]  DICT_RESET = CFG_W'(8192);
  localparam logic [KEPT_W-1:0] KEPT_MAX   = {KEPT_W{1'b1}};
  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef logic signed [SCORE_W-1:0] score_t;
  typedef logic signed [SUM_W-1:0]   sum_t;

  typedef struct packed {
    logic               has_label;
    logic [LABEL_W-1:0] label;
    logic               has_summary;
    sum_t               sum;
    logic [KEPT_W-1:0]  kept;
  } q_entry_t;

endpackage
`default_nettype wire

>>> rtl/ctcg_in_if.sv
// score input channel
`default_nettype none
interface ctcg_in_if;
  import ctcg_pkg::*;

  logic   valid;
  logic   ready;
  score_t score;
  logic   end_of_step;
  logic   end_of_sequence;

  modport source (output valid, output score, output end_of_step, output end_of_sequence,
                  input ready);
  modport sink (input valid, input score, input end_of_step, input end_of_sequence,
                output ready);
endinterface
`default_nettype wire

>>> rtl/ctcg_out_if.sv
// result output channel
`default_nettype none
interface ctcg_out_if;
  import ctcg_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      is_summary;
  logic [LABEL_W-1:0]        label;
  logic [KEPT_W-1:0]         kept_labels;
  logic signed [MEAN_W-1:0]  avg_score;
  logic                      last;

  modport source (output valid, output is_summary, output label, output kept_labels,
                  output avg_score, output last, input ready);
  modport sink (input valid, input is_summary, input label, input kept_labels,
                input avg_score, input last, output ready);
endinterface
`default_nettype wire

>>> rtl/ctcg_front.sv
// front part: per-step argmax, collapse, blank and dict_size filter, running sum and count
`default_nettype none
module ctcg_front #(
  parameter int MAX_CLASSES = ctcg_pkg::MAX_CLASSES_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_we,
  input  wire logic [ctcg_pkg::CFG_W-1:0] cfg_wdata,
  ctcg_in_if.sink                       in_ch,
  output      logic                     push,
  output      ctcg_pkg::q_entry_t       entry,
  input  wire logic                     q_full
);
  import ctcg_pkg::*;

  localparam int CW   = $clog2(MAX_CLASSES);
  localparam int CNTW = $clog2(MAX_CLASSES + 1);
  localparam int CMPW = ((CW > CFG_W) ? CW : CFG_W) + 1;

  logic [CFG_W-1:0]  dict_size_r;
  logic [CNTW-1:0]   cnt_r;
  score_t            best_score_r;
  logic [CW-1:0]     best_class_r;
  logic [CW-1:0]     prev_class_r;
  logic              first_r;
  sum_t              sum_r;
  logic [KEPT_W-1:0] kept_r;

  logic              accept;
  logic              eos;
  logic              eoq;
  logic              counting;
  logic              take;
  score_t            best_score_c;
  logic [CW-1:0]     best_class_c;
  logic              dup;
  logic              keep;
  logic signed [SUM_W:0] sum_wide;
  sum_t              sum_sat;
  sum_t              sum_new;
  logic [KEPT_W-1:0] kept_new;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;
  assign eos         = accept && in_ch.end_of_step;
  assign eoq         = eos && in_ch.end_of_sequence;

  assign counting     = cnt_r < CNTW'(MAX_CLASSES);
  assign take         = counting && ((cnt_r == '0) || (in_ch.score > best_score_r));
  assign best_score_c = take ? in_ch.score : best_score_r;
  assign best_class_c = take ? cnt_r[CW-1:0] : best_class_r;

  assign dup  = !first_r && (best_class_c == prev_class_r);
  assign keep = !dup && (best_class_c != '0) &&
                (CMPW'(best_class_c) < CMPW'(dict_size_r));

  assign sum_wide = (SUM_W+1)'(sum_r) + (SUM_W+1)'(best_score_c);

  always_comb begin
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      sum_sat = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_sat = sum_wide[SUM_W-1:0];
    end
  end

  assign sum_new  = keep ? sum_sat : sum_r;
  assign kept_new = (keep && (kept_r != KEPT_MAX)) ? kept_r + 1'b1 : kept_r;

  assign push              = eos && (keep || eoq);
  assign entry.has_label   = keep;
  assign entry.label       = LABEL_W'(best_class_c);
  assign entry.has_summary = eoq;
  assign entry.sum         = sum_new;
  assign entry.kept        = kept_new;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dict_size_r <= DICT_RESET;
    end else if (cfg_we) begin
      dict_size_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      best_score_r <= '0;
      best_class_r <= '0;
      prev_class_r <= '0;
      first_r      <= 1'b1;
      sum_r        <= '0;
      kept_r       <= '0;
    end else if (accept) begin
      if (eos) begin
        cnt_r        <= '0;
        best_score_r <= '0;
        best_class_r <= '0;
        if (eoq) begin
          prev_class_r <= '0;
          first_r      <= 1'b1;
          sum_r        <= '0;
          kept_r       <= '0;
        end else begin
          prev_class_r <= best_class_c;
          first_r      <= 1'b0;
          sum_r        <= sum_new;
          kept_r       <= kept_new;
        end
      end else begin
        cnt_r        <= counting ? cnt_r + 1'b1 : cnt_r;
        best_score_r <= best_score_c;
        best_class_r <= best_class_c;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/ctcg_queue.sv
// short queue of decoded step results between front and back
`default_nettype none
module ctcg_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire ctcg_pkg::q_entry_t wr_data,
  input  wire logic               pop,
  output      ctcg_pkg::q_entry_t rd_data,
  output      logic               full,
  output      logic               empty
);
  import ctcg_pkg::*;

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  q_entry_t        mem [QDEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [CW-1:0]   cnt_r;
  logic            do_push;
  logic            do_pop;

  assign full    = cnt_r == CW'(QDEPTH);
  assign empty   = cnt_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/ctcg_back.sv
// back part: label output and serial mean division for the summary
`default_nettype none
module ctcg_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_empty,
  input  wire ctcg_pkg::q_entry_t q_data,
  output      logic               pop,
  ctcg_out_if.source              out_ch
);
  import ctcg_pkg::*;

  localparam int STW = $clog2(SUM_W);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_EMIT = 3'b100
  } back_st_t;

  localparam logic [SUM_W-1:0] POS_LIM = SUM_W'((1 << (MEAN_W - 1)) - 1);
  localparam logic [SUM_W-1:0] NEG_LIM = SUM_W'(1 << (MEAN_W - 1));

  back_st_t               state_r;
  back_st_t               state_nxt;
  logic                   neg_r;
  logic [KEPT_W-1:0]      rem_r;
  logic [SUM_W-1:0]       quo_r;
  logic [KEPT_W-1:0]      div_r;
  logic [STW-1:0]         step_r;

  logic                   out_valid_r;
  logic                   is_summary_r;
  logic [LABEL_W-1:0]     label_r;
  logic [KEPT_W-1:0]      kept_labels_r;
  logic signed [MEAN_W-1:0] mean_r;
  logic                   last_r;

  logic                   out_free;
  logic                   load_label;
  logic                   load_summary;
  logic                   start_div;
  logic [KEPT_W:0]        rem_sh;
  logic                   ge;
  logic [KEPT_W:0]        rem_sub;
  logic signed [MEAN_W-1:0] mean_c;

  assign out_free = !out_valid_r || out_ch.ready;

  assign pop        = (state_r == ST_IDLE) && !q_empty && (!q_data.has_label || out_free);
  assign load_label = pop && q_data.has_label;
  assign start_div  = pop && q_data.has_summary;
  assign load_summary = (state_r == ST_EMIT) && out_free;

  assign rem_sh  = {rem_r, quo_r[SUM_W-1]};
  assign ge      = rem_sh >= {1'b0, div_r};
  assign rem_sub = rem_sh - {1'b0, div_r};

  always_comb begin
    if (div_r == '0) begin
      mean_c = '0;
    end else if (!neg_r) begin
      mean_c = (quo_r > POS_LIM) ? MEAN_W'(POS_LIM) : quo_r[MEAN_W-1:0];
    end else begin
      mean_c = (quo_r > NEG_LIM) ? MEAN_W'(NEG_LIM) : -quo_r[MEAN_W-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start_div) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (step_r == STW'(SUM_W - 1)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start_div) begin
      neg_r  <= q_data.sum[SUM_W-1];
      quo_r  <= q_data.sum[SUM_W-1] ? -q_data.sum : q_data.sum;
      rem_r  <= '0;
      div_r  <= q_data.kept;
      step_r <= '0;
    end else if (state_r == ST_DIV) begin
      rem_r  <= ge ? rem_sub[KEPT_W-1:0] : rem_sh[KEPT_W-1:0];
      quo_r  <= {quo_r[SUM_W-2:0], ge};
      step_r <= step_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_label || load_summary) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_label) begin
      is_summary_r  <= 1'b0;
      label_r       <= q_data.label;
      kept_labels_r <= '0;
      mean_r        <= '0;
      last_r        <= !q_data.has_summary;
    end else if (load_summary) begin
      is_summary_r  <= 1'b1;
      label_r       <= '0;
      kept_labels_r <= div_r;
      mean_r        <= mean_c;
      last_r        <= 1'b1;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.is_summary  = is_summary_r;
  assign out_ch.label       = label_r;
  assign out_ch.kept_labels = kept_labels_r;
  assign out_ch.avg_score   = mean_r;
  assign out_ch.last        = last_r;

endmodule
`default_nettype wire

>>> rtl/ctc_greedy_decoder_unit.sv
// top level of the ctc greedy best-path decoder
// Scores enter one per cycle, class by class; the front part tracks the argmax
// of each timestep and, at step end, drops blanks, repeats and classes at or
// above dict_size, keeping the running score sum and kept count. Decoded steps
// go through a two-entry queue to the back part. A label result leaves in the
// cycle after the back part takes it from the queue; a sequence summary is
// formed there by the one-bit-per-cycle division of the 27-bit score sum
// by the kept count (load, 27 steps, then output). The input keeps taking a
// score every cycle while the queue has room; while a summary divides, the
// queue holds two more decoded steps (kept steps or sequence ends); once it
// is full, the input is held off until the division is done, and a stalled
// result output holds it off too. dict_size may be written only while idle.
`default_nettype none
module ctc_greedy_decoder_unit #(
  parameter int MAX_CLASSES = ctcg_pkg::MAX_CLASSES_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [ctcg_pkg::CFG_W-1:0] cfg_wdata,
  ctcg_in_if.sink                         in_ch,
  ctcg_out_if.source                      out_ch
);
  import ctcg_pkg::*;

  logic     push;
  logic     pop;
  logic     q_full;
  logic     q_empty;
  q_entry_t wr_entry;
  q_entry_t rd_entry;

  ctcg_front #(
    .MAX_CLASSES (MAX_CLASSES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .push      (push),
    .entry     (wr_entry),
    .q_full    (q_full)
  );

  ctcg_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (wr_entry),
    .pop     (pop),
    .rd_data (rd_entry),
    .full    (q_full),
    .empty   (q_empty)
  );

  ctcg_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_data  (rd_entry),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule
`default_nettype wire

>>> rtl/ctcg_checker.sv
// port-level checks of the decoder's result stream and their binding
`default_nettype none
module ctcg_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic                         is_summary,
  input wire logic [ctcg_pkg::LABEL_W-1:0] label,
  input wire logic [ctcg_pkg::KEPT_W-1:0]  kept_labels,
  input wire logic [ctcg_pkg::MEAN_W-1:0]  avg_score,
  input wire logic                         last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && is_summary |-> last && (label == '0))
    else $error("summary not last or carries a label");

  a_label_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !is_summary |-> (kept_labels == '0) && (avg_score == '0)
                                 && (label != '0))
    else $error("label result with summary fields or blank label");

  a_empty_mean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && is_summary && (kept_labels == '0) |-> avg_score == '0)
    else $error("nonzero mean with nothing kept");

  a_label_then_summary: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !is_summary && !last |=>
      !out_valid || is_summary)
    else $error("label without last not followed by summary");

endmodule

bind ctc_greedy_decoder_unit ctcg_checker u_ctcg_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .is_summary  (out_ch.is_summary),
  .label       (out_ch.label),
  .kept_labels (out_ch.kept_labels),
  .avg_score   (out_ch.avg_score),
  .last        (out_ch.last)
);
`default_nettype wire

>>> sim/tb_ctc_greedy_decoder_unit.sv
// testbench for the ctc greedy decoder: directed and random score streams checked beat by beat
`timescale 1ns / 1ps
module tb_ctc_greedy_decoder_unit;
  import ctcg_pkg::*;

  localparam int CLASS_LIMIT = MAX_CLASSES_DEF;
  localparam int TAIL_CYCLES = 40;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_TARGET = 640;
  localparam score_t SCORE_TOP = 16'sh7fff;
  localparam score_t SCORE_BOTTOM = 16'sh8000;

  typedef struct packed {
    logic                     is_summary;
    logic [LABEL_W-1:0]       label;
    logic [KEPT_W-1:0]        kept_labels;
    logic signed [MEAN_W-1:0] avg_score;
    logic                     last;
  } decoded_t;

  class ctc_path_scoreboard;
    score_t             best_score;
    logic [LABEL_W-1:0] best_class;
    int unsigned        class_count;
    logic [LABEL_W-1:0] prev_class;
    bit                 first_step;
    longint             sum_acc;
    int unsigned        kept_total;
    int unsigned        dict_size;
    decoded_t           decoded_due[$];
    int                 errors;
    int                 labels_seen;
    int                 summaries_seen;

    function new();
      best_score = '0;
      best_class = '0;
      class_count = 0;
      prev_class = '0;
      first_step = 1'b1;
      sum_acc = 0;
      kept_total = 0;
      dict_size = DICT_RESET;
      errors = 0;
      labels_seen = 0;
      summaries_seen = 0;
    endfunction

    function void set_dict(int unsigned value);
      dict_size = value & 32'h3fff;
    endfunction

    function int pending();
      return decoded_due.size();
    endfunction

    function void add_due(decoded_t d);
      decoded_due.insert(decoded_due.size(), d);
    endfunction

    function void note_score(score_t s, bit step_end, bit seq_flag);
      bit                 seq_end;
      bit                 dup;
      logic [LABEL_W-1:0] win;
      longint             t;
      longint             mean;
      decoded_t           beat;
      seq_end = step_end && seq_flag;
      if (class_count < CLASS_LIMIT) begin
        if (class_count == 0 || s > best_score) begin
          best_score = s;
          best_class = LABEL_W'(class_count);
        end
        class_count++;
      end
      if (!step_end) return;
      win = best_class;
      dup = !first_step && win == prev_class;
      prev_class = win;
      first_step = 1'b0;
      if (!dup && win != 0 && win < dict_size) begin
        t = sum_acc + longint'(best_score);
        if (t > longint'(SUM_MAX)) t = longint'(SUM_MAX);
        if (t < longint'(SUM_MIN)) t = longint'(SUM_MIN);
        sum_acc = t;
        if (kept_total < KEPT_MAX) kept_total++;
        beat = '{is_summary: 1'b0, label: win, kept_labels: '0,
                 avg_score: '0, last: !seq_end};
        add_due(beat);
      end
      class_count = 0;
      best_score = '0;
      best_class = '0;
      if (seq_end) begin
        mean = 0;
        if (kept_total > 0) mean = sum_acc / longint'(kept_total);
        if (mean > 32767) mean = 32767;
        if (mean < -32768) mean = -32768;
        beat = '{is_summary: 1'b1, label: '0, kept_labels: KEPT_W'(kept_total),
                 avg_score: MEAN_W'(mean), last: 1'b1};
        add_due(beat);
        sum_acc = 0;
        kept_total = 0;
        first_step = 1'b1;
        prev_class = '0;
      end
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch at %0t: %s", $time, msg);
    endtask

    task check_field(string name, logic [31:0] got, logic [31:0] want, int idx);
      if (got !== want)
        report($sformatf("beat %0d %s got 0x%0h expected 0x%0h", idx, name, got, want));
    endtask

    task check_result(decoded_t got);
      decoded_t want;
      int       idx;
      idx = labels_seen + summaries_seen;
      if (decoded_due.size() == 0) begin
        report($sformatf("beat %0d arrived with nothing outstanding", idx));
        return;
      end
      want = decoded_due.pop_front();
      check_field("is_summary", got.is_summary, want.is_summary, idx);
      check_field("label", got.label, want.label, idx);
      check_field("kept_labels", got.kept_labels, want.kept_labels, idx);
      check_field("avg_score", got.avg_score, want.avg_score, idx);
      check_field("last", got.last, want.last, idx);
      if (want.is_summary) summaries_seen++;
      else labels_seen++;
    endtask
  endclass

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  ctcg_in_if  in_ch ();
  ctcg_out_if out_ch ();

  ctc_greedy_decoder_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  ctc_path_scoreboard sb;
  int scores_sent;
  int settings_used;
  int pressure_req;
  int pressure_done;
  bit in_idle_on;
  bit no_gaps;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #30ms;
    $display("ctc_greedy_decoder_unit test failed");
    $finish;
  end

  function automatic score_t pick_score();
    case ($urandom_range(0, 3))
      0: return score_t'($urandom);
      1: return score_t'($urandom_range(0, 3));
      2: return $urandom_range(0, 1) ? SCORE_TOP : SCORE_BOTTOM;
      default: return score_t'(int'($urandom_range(0, 600)) - 300);
    endcase
  endfunction

  task automatic send_score(score_t s, bit step_end, bit seq_flag);
    int gap;
    if (scores_sent % 50 == 0) in_idle_on = $urandom_range(0, 2) != 0;
    gap = (in_idle_on && !no_gaps) ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.score <= s;
    in_ch.end_of_step <= step_end;
    in_ch.end_of_sequence <= seq_flag;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_score(s, step_end, seq_flag);
    scores_sent++;
  endtask

  // mid-step beats carry a random sequence flag, which must be ignored
  task automatic send_step(score_t cls[$], bit seq_end);
    int c;
    for (c = 0; c < cls.size(); c++) begin
      if (c == cls.size() - 1) send_score(cls[c], 1'b1, seq_end);
      else send_score(cls[c], 1'b0, 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_dict(int unsigned value);
    cfg_wdata <= CFG_W'(value);
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_dict(value);
    settings_used++;
  endtask

  task automatic random_sequence();
    score_t cls[$];
    int     steps;
    int     n;
    int     s;
    int     c;
    steps = $urandom_range(1, 10);
    for (s = 0; s < steps; s++) begin
      cls.delete();
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
      for (c = 0; c < n; c++) cls.insert(cls.size(), pick_score());
      send_step(cls, s == steps - 1);
    end
  endtask

  task automatic drain_results();
    int       stall;
    int       beats;
    bit       idle_on;
    decoded_t got;
    beats = 0;
    idle_on = 1'b1;
    forever begin
      if (pressure_done != pressure_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        pressure_done++;
      end
      if (beats % 20 == 0) idle_on = $urandom_range(0, 2) != 0;
      stall = idle_on ? $urandom_range(0, 19) : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      got = '{out_ch.is_summary, out_ch.label, out_ch.kept_labels, out_ch.avg_score,
              out_ch.last};
      sb.check_result(got);
      beats++;
    end
  endtask

  initial begin
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    drain_results();
  end

  initial begin
    score_t cls[$];
    int     plan[6];
    int     phase;
    int     base;
    int     start;
    sb = new();
    scores_sent = 0;
    settings_used = 0;
    pressure_req = 0;
    pressure_done = 0;
    in_idle_on = 1'b1;
    no_gaps = 1'b0;
    plan = '{0, 1, 2, 8192, 3, 6};
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.score <= '0;
    in_ch.end_of_step <= 1'b0;
    in_ch.end_of_sequence <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // tie to lowest index, repeat, blank, repeat after blank, extremes
    cls = '{0, 100, 100};
    send_step(cls, 1'b0);
    cls = '{0, 50, 200};
    send_step(cls, 1'b0);
    cls = '{7, 50, 200};
    send_step(cls, 1'b0);
    cls = '{300, 0};
    send_step(cls, 1'b0);
    cls = '{-5, -6, 200};
    send_step(cls, 1'b0);
    cls = '{SCORE_BOTTOM, SCORE_TOP};
    send_step(cls, 1'b0);
    cls = '{42};
    send_step(cls, 1'b1);
    // negative mean truncates toward zero, label and summary from one beat
    cls = '{SCORE_BOTTOM, -3};
    send_step(cls, 1'b0);
    cls = '{SCORE_BOTTOM, SCORE_BOTTOM, -4};
    send_step(cls, 1'b1);
    // nothing kept
    cls = '{5};
    send_step(cls, 1'b1);
    settle();

    write_dict(16383);
    no_gaps = 1'b1;
    pressure_req++;
    repeat (40) begin
      cls = '{0, 100};
      send_step(cls, 1'b1);
    end
    no_gaps = 1'b0;
    settle();

    base = scores_sent;
    phase = 0;
    while (scores_sent - base < RANDOM_TARGET) begin
      write_dict(phase < 6 ? plan[phase] : $urandom_range(1, 12));
      start = scores_sent;
      while (scores_sent - start < 90) random_sequence();
      settle();
      phase++;
    end

    $display("run covered %0d score beats and %0d dictionary settings", scores_sent,
             settings_used);
    $display("checked %0d label beats and %0d summary beats", sb.labels_seen,
             sb.summaries_seen);
    if (sb.errors == 0) begin
      $display("ctc_greedy_decoder_unit test passed");
    end else begin
      $display("ctc_greedy_decoder_unit test failed");
    end
    $finish;
  end

endmodule

>>> ctc_greedy_decoder_unit.f
rtl/ctcg_pkg.sv
rtl/ctcg_in_if.sv
rtl/ctcg_out_if.sv
rtl/ctcg_front.sv
rtl/ctcg_queue.sv
rtl/ctcg_back.sv
rtl/ctc_greedy_decoder_unit.sv
rtl/ctcg_checker.sv
sim/tb_ctc_greedy_decoder_unit.sv
